/* sv/uer_pkg.sv */
// ----------------------------------------------------------------------------
// uer_pkg
// shared types and constants of the ultrasonic echo ranger
// ----------------------------------------------------------------------------
package uer_pkg;

  // width of the echo counter and of the distance quotient
  localparam int unsigned COUNT_BITS = 20;
  localparam int unsigned DIV_CNT_W  = $clog2(COUNT_BITS);
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned DATA_W     = 32;

  // register reset values
  localparam logic [7:0]  TRIG_WIDTH_RST   = 8'd10;
  localparam logic [15:0] PING_TIMEOUT_RST = 16'd1000;
  localparam logic [7:0]  GLITCH_DELAY_RST = 8'd5;
  localparam logic [19:0] ECHO_TIMEOUT_RST = 20'd18000;
  localparam logic [7:0]  US_PER_CM_RST    = 8'd58;

  typedef enum logic [2:0] {
    REG_TRIG_WIDTH   = 3'd0,
    REG_PING_TIMEOUT = 3'd1,
    REG_GLITCH_DELAY = 3'd2,
    REG_ECHO_TIMEOUT = 3'd3,
    REG_US_PER_CM    = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_ECHO_HIGH    = 2'd1,
    ST_PING_TIMEOUT = 2'd2,
    ST_ECHO_TIMEOUT = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0]  trigger_width_us;
    logic [15:0] ping_limit;
    logic [7:0]  glitch_delay_us;
    logic [19:0] echo_timeout_us;
    logic [7:0]  us_per_cm;
  } cfg_t;

  // result of one tick as seen by the sequencer
  typedef struct packed {
    logic                  trigger_out;
    logic                  busy_res;
    logic                  done_res;
    status_e               status;
    logic [COUNT_BITS-1:0] echo_time_us;
    logic [COUNT_BITS-1:0] distance_cm;
    logic                  need_div;
  } res_t;

endpackage

/* sv/uer_regs.sv */
// ----------------------------------------------------------------------------
// uer_regs
// configuration register file behind the apb-style port
// ----------------------------------------------------------------------------
module uer_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [uer_pkg::ADDR_W-1:0] paddr,
  input  logic [uer_pkg::DATA_W-1:0] pwdata,
  output logic [uer_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output uer_pkg::cfg_t              cfg_o
);

  uer_pkg::cfg_t     cfg_q, cfg_d;
  uer_pkg::reg_idx_e idx;
  logic              wr_en;

  assign idx    = uer_pkg::reg_idx_e'(paddr[uer_pkg::ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        uer_pkg::REG_TRIG_WIDTH:   cfg_d.trigger_width_us = pwdata[7:0];
        uer_pkg::REG_PING_TIMEOUT: cfg_d.ping_limit       = pwdata[15:0];
        uer_pkg::REG_GLITCH_DELAY: cfg_d.glitch_delay_us  = pwdata[7:0];
        uer_pkg::REG_ECHO_TIMEOUT: cfg_d.echo_timeout_us  = pwdata[19:0];
        uer_pkg::REG_US_PER_CM:    cfg_d.us_per_cm        = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      uer_pkg::REG_TRIG_WIDTH:   prdata[7:0]  = cfg_q.trigger_width_us;
      uer_pkg::REG_PING_TIMEOUT: prdata[15:0] = cfg_q.ping_limit;
      uer_pkg::REG_GLITCH_DELAY: prdata[7:0]  = cfg_q.glitch_delay_us;
      uer_pkg::REG_ECHO_TIMEOUT: prdata[19:0] = cfg_q.echo_timeout_us;
      uer_pkg::REG_US_PER_CM:    prdata[7:0]  = cfg_q.us_per_cm;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_width_us <= uer_pkg::TRIG_WIDTH_RST;
      cfg_q.ping_limit       <= uer_pkg::PING_TIMEOUT_RST;
      cfg_q.glitch_delay_us  <= uer_pkg::GLITCH_DELAY_RST;
      cfg_q.echo_timeout_us  <= uer_pkg::ECHO_TIMEOUT_RST;
      cfg_q.us_per_cm        <= uer_pkg::US_PER_CM_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* sv/uer_seq.sv */
// ----------------------------------------------------------------------------
// uer_seq
// per-tick ranging sequencer: trigger, echo wait, glitch check, measure
// ----------------------------------------------------------------------------
module uer_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          tick_i,
  input  logic          start_req_i,
  input  logic          echo_level_i,
  input  uer_pkg::cfg_t cfg_i,
  output uer_pkg::res_t res_o
);

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_TRIG    = 5'b00010,
    PH_WAIT    = 5'b00100,
    PH_GLITCH  = 5'b01000,
    PH_MEASURE = 5'b10000
  } phase_e;

  phase_e                         phase_q, phase_d;
  logic [7:0]                     step_q, step_d, step_inc;
  logic [15:0]                    ping_q, ping_d, ping_inc;
  logic [uer_pkg::COUNT_BITS-1:0] echo_q, echo_d;

  assign step_inc = step_q + 8'd1;
  assign ping_inc = (ping_q == '1) ? ping_q : ping_q + 16'd1;

  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    ping_d  = ping_q;
    echo_d  = echo_q;
    res_o   = '0;
    res_o.status = uer_pkg::ST_OK;
    unique case (phase_q)
      PH_IDLE: begin
        if (start_req_i) begin
          if (echo_level_i) begin
            res_o.done_res = 1'b1;
            res_o.status   = uer_pkg::ST_ECHO_HIGH;
          end else begin
            res_o.trigger_out = 1'b1;
            step_d  = 8'd1;
            ping_d  = '0;
            echo_d  = '0;
            phase_d = (8'd1 >= cfg_i.trigger_width_us) ? PH_WAIT : PH_TRIG;
          end
        end
      end
      PH_TRIG: begin
        res_o.trigger_out = 1'b1;
        step_d = step_inc;
        if (step_inc >= cfg_i.trigger_width_us) begin
          phase_d = PH_WAIT;
        end
      end
      PH_WAIT: begin
        ping_d = ping_inc;
        if (echo_level_i) begin
          if (cfg_i.glitch_delay_us == 8'd0) begin
            echo_d  = '0;
            phase_d = PH_MEASURE;
          end else begin
            step_d  = 8'd0;
            phase_d = PH_GLITCH;
          end
        end else if (ping_inc >= cfg_i.ping_limit) begin
          res_o.done_res = 1'b1;
          res_o.status   = uer_pkg::ST_PING_TIMEOUT;
          phase_d        = PH_IDLE;
        end
      end
      PH_GLITCH: begin
        ping_d = ping_inc;
        step_d = step_inc;
        if (step_inc >= cfg_i.glitch_delay_us) begin
          if (echo_level_i) begin
            echo_d  = '0;
            phase_d = PH_MEASURE;
          end else begin
            phase_d = PH_WAIT;
          end
        end
      end
      PH_MEASURE: begin
        if (!echo_level_i) begin
          res_o.done_res     = 1'b1;
          res_o.echo_time_us = echo_q;
          // zero divisor reads as all ones, otherwise the divider fills it in
          if (cfg_i.us_per_cm == 8'd0) begin
            res_o.distance_cm = '1;
          end else begin
            res_o.need_div = 1'b1;
          end
          phase_d = PH_IDLE;
        end else if (echo_q >= cfg_i.echo_timeout_us) begin
          res_o.done_res = 1'b1;
          res_o.status   = uer_pkg::ST_ECHO_TIMEOUT;
          phase_d        = PH_IDLE;
        end else if (echo_q != '1) begin
          echo_d = echo_q + uer_pkg::COUNT_BITS'(1);
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
    res_o.busy_res = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      step_q  <= '0;
      ping_q  <= '0;
      echo_q  <= '0;
    end else if (tick_i) begin
      phase_q <= phase_d;
      step_q  <= step_d;
      ping_q  <= ping_d;
      echo_q  <= echo_d;
    end
  end

endmodule

/* sv/uer_div.sv */
// ----------------------------------------------------------------------------
// uer_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module uer_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [uer_pkg::COUNT_BITS-1:0] dividend_i,
  input  logic [7:0]                     divisor_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic [uer_pkg::COUNT_BITS-1:0] quotient_o
);

  localparam logic [uer_pkg::DIV_CNT_W-1:0] LAST_STEP =
    uer_pkg::DIV_CNT_W'(uer_pkg::COUNT_BITS - 1);

  logic                           busy_q, busy_d;
  logic [uer_pkg::DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [7:0]                     rem_q, rem_d, dvs_q;
  logic [uer_pkg::COUNT_BITS-1:0] quo_q, quo_d;
  logic [8:0]                     rem_sh, diff;
  logic                           ge;

  assign rem_sh = {rem_q, quo_q[uer_pkg::COUNT_BITS-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = (rem_sh >= {1'b0, dvs_q});

  assign busy_o     = busy_q;
  assign done_o     = busy_q && (cnt_q == LAST_STEP);
  assign quotient_o = {quo_q[uer_pkg::COUNT_BITS-2:0], ge};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[7:0] : rem_sh[7:0];
      quo_d = {quo_q[uer_pkg::COUNT_BITS-2:0], ge};
      cnt_d = cnt_q + uer_pkg::DIV_CNT_W'(1);
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

endmodule

/* sv/ultrasonic_echo_ranger.sv */
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// tick-driven ultrasonic ranging controller with iterative distance divide
// ----------------------------------------------------------------------------
// a taken request's result is registered and shown in the cycle after it; the tick
//   that ends a good measurement also waits for the 20 divider steps
// throughput: 1 tick per cycle while in_stall_o is low; a divide-ending tick holds off new ticks while the divider runs
// the distance divide runs on a restoring divider, 1 bit per cycle
// reset: asynchronous active-low rst_ni; sequencer idle, counters zero,
//   registers at their defaults, no result pending
module ultrasonic_echo_ranger (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // apb-style configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [uer_pkg::ADDR_W-1:0]     paddr,
  input  logic [uer_pkg::DATA_W-1:0]     pwdata,
  output logic [uer_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  // tick request channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           start_req_i,
  input  logic                           echo_level_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           trigger_out_o,
  output logic                           busy_res_o,
  output logic                           done_res_o,
  output logic [1:0]                     status_o,
  output logic [uer_pkg::COUNT_BITS-1:0] echo_time_us_o,
  output logic [uer_pkg::COUNT_BITS-1:0] distance_cm_o
);

  uer_pkg::cfg_t                  cfg;
  uer_pkg::res_t                  res;
  logic                           tick_acc;
  logic                           div_busy, div_done;
  logic [uer_pkg::COUNT_BITS-1:0] div_quo;

  // output register
  logic                           out_valid_q, out_valid_d;
  logic                           trig_q, busy_q, done_q;
  uer_pkg::status_e               status_q;
  logic [uer_pkg::COUNT_BITS-1:0] echo_time_q, dist_q;

  uer_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // a new request waits while the divider runs or a result is held back
  assign in_stall_o = div_busy | (out_valid_q & out_stall_i);
  assign tick_acc   = in_valid_i & ~in_stall_o;

  uer_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick_acc),
    .start_req_i  (start_req_i),
    .echo_level_i (echo_level_i),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  // distance is only computed on the tick that closes a good measurement
  uer_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (tick_acc & res.need_div),
    .dividend_i (res.echo_time_us),
    .divisor_i  (cfg.us_per_cm),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // result is shown at once, or held back until the quotient is ready
  always_comb begin
    out_valid_d = out_valid_q;
    priority if (tick_acc) begin
      out_valid_d = ~res.need_div;
    end else if (div_done) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      trig_q      <= res.trigger_out;
      busy_q      <= res.busy_res;
      done_q      <= res.done_res;
      status_q    <= res.status;
      echo_time_q <= res.echo_time_us;
      dist_q      <= res.distance_cm;
    end else if (div_done) begin
      dist_q <= div_quo;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign trigger_out_o  = trig_q;
  assign busy_res_o     = busy_q;
  assign done_res_o     = done_q;
  assign status_o       = status_q;
  assign echo_time_us_o = echo_time_q;
  assign distance_cm_o  = dist_q;

`ifndef NO_ASSERTIONS
  // a finished measurement never reports the block as still busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done result with busy set");

  // trigger high only while a measurement is running
  a_trig_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && trigger_out_o |-> busy_res_o)
    else $error("trigger high outside a measurement");

  // no status and no width unless the tick finished a measurement
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |->
      status_o == uer_pkg::ST_OK && echo_time_us_o == '0)
    else $error("status or width on a tick that did not finish");

  // a divide-ending tick holds its result back until the quotient lands
  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc && res.need_div |=> !out_valid_o && div_busy)
    else $error("result shown before distance divide");
`endif

endmodule
